FILE: sv/first_fit_block_allocator_macros.svh
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FFBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ffba_pkg.sv
// Shared types, codes and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int CNT_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd0;
    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 24'd65536;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] len;
        logic [SIZE_W-1:0] off;
    } t_entry;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_FAIL,
        DP_RD_IDX,
        DP_ADV,
        DP_TAKE,
        DP_RD_KM1,
        DP_WR_K,
        DP_SPLIT_NEW,
        DP_ALLOC_DONE,
        DP_RD_NXT,
        DP_MERGE_NXT,
        DP_RD_KP1,
        DP_WR_DN,
        DP_DEC,
        DP_RD_PRV,
        DP_MERGE_PRV,
        DP_WR_CUR,
        DP_PUSH
    } t_dp_op;

    typedef struct packed {
        logic is_free;
        logic want_zero;
        logic idx_end;
        logic hit;
        logic split;
        logic up_more;
        logic dn_more;
        logic nxt_exists;
        logic idx_nz;
        logic merge_nxt;
        logic merge_prv;
    } t_dp_status;

endpackage

FILE: sv/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: ports, controller and datapath.
// The block keeps an ordered table of up to TABLE_DEPTH blocks covering one pool and serves
// one allocate or free transaction at a time, with one result transaction for each. The table
// lives in a single memory with one registered read and one write a cycle, so every entry
// visited takes a read and then a check or write: a request scans the entries in order from
// entry 0, a split moves every entry above the chosen one up by one, and a free checks the
// next and previous neighbors for a merge and moves the entries above a merged one down.
// After reset the initial free block is written before the first request is taken; a
// pool_size write rebuilds the table at once. The result sits in an output register, so the
// next request is taken while an earlier result waits.
module first_fit_block_allocator #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [55:0]                    s_axis_tdata,  // request_size, release_addr
    input  logic                           s_axis_tuser,  // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // result_addr, entries_in_use, pad
    output logic                           m_axis_tuser,  // success
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]    i_cfg_data
);
    import ffba_pkg::*;

    t_dp_op            w_op;
    t_dp_status        w_status;
    logic [ADDR_W-1:0] w_result_addr;
    logic              w_success;
    logic [CNT_W-1:0]  w_entries;
    logic              w_in_ready;

    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_op        (w_op)
    );

    ffba_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (s_axis_tuser),
        .i_request_size   (s_axis_tdata[23:0]),
        .i_release_addr   (s_axis_tdata[55:24]),
        .o_result_addr    (w_result_addr),
        .o_success        (w_success),
        .o_entries_in_use (w_entries)
    );

    assign s_axis_tready = w_in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {3'b000, w_entries, w_result_addr};
    assign m_axis_tuser  = w_success;

endmodule

FILE: sv/ffba_dp.sv
// Datapath of the allocator: block table memory, scan and shift counters, result registers.
`include "first_fit_block_allocator_macros.svh"
module ffba_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffba_pkg::t_dp_op                  i_op,
    output ffba_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              i_action,
    input  logic [ffba_pkg::SIZE_W-1:0]       i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]       i_release_addr,
    output logic [ffba_pkg::ADDR_W-1:0]       o_result_addr,
    output logic                              o_success,
    output logic [ffba_pkg::CNT_W-1:0]        o_entries_in_use
);
    import ffba_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = $clog2(TABLE_DEPTH + 1);

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rdata;
    t_entry            r_cur;
    logic [ADDR_W-1:0] r_pool_base;
    logic [SIZE_W-1:0] r_pool_size;
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     r_idx;
    logic [TW-1:0]     r_k;
    logic [SIZE_W-1:0] r_want;
    logic [ADDR_W-1:0] r_rel;
    logic              r_is_free;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_res_ok;
    logic [ADDR_W-1:0] r_o_addr;
    logic              r_o_ok;
    logic [CNT_W-1:0]  r_o_cnt;

    logic [TW-1:0]     w_idx_p1;
    logic [TW-1:0]     w_idx_m1;
    logic [TW-1:0]     w_k_p1;
    logic [TW-1:0]     w_k_m1;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [31:0]       w_total_wide;
    logic              w_split;
    logic              w_cfg_size;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [IW-1:0]     w_raddr;
    logic              w_re;
    t_entry            w_wdata;

    assign w_idx_p1     = r_idx + TW'(1);
    assign w_idx_m1     = r_idx - TW'(1);
    assign w_k_p1       = r_k + TW'(1);
    assign w_k_m1       = r_k - TW'(1);
    assign w_rd_addr    = r_pool_base + {{(ADDR_W-SIZE_W){1'b0}}, r_rdata.off};
    assign w_cur_addr   = r_pool_base + {{(ADDR_W-SIZE_W){1'b0}}, r_cur.off};
    assign w_total_wide = 32'(r_total);
    assign w_split      = (r_cur.len > r_want) && (r_total < TW'(TABLE_DEPTH));
    assign w_cfg_size   = i_cfg_we && (i_cfg_index == CFG_POOL_SIZE);

    always_comb begin
        o_status.is_free    = r_is_free;
        o_status.want_zero  = (r_want == '0);
        o_status.idx_end    = (r_idx == r_total);
        o_status.hit        = r_is_free ? (r_rdata.used && (w_rd_addr == r_rel))
                                        : (!r_rdata.used && (r_rdata.len >= r_want));
        o_status.split      = w_split;
        o_status.up_more    = (r_k > w_idx_p1);
        o_status.dn_more    = (w_k_p1 < r_total);
        o_status.nxt_exists = (w_idx_p1 < r_total);
        o_status.idx_nz     = (r_idx != '0);
        o_status.merge_nxt  = !r_rdata.used &&
                              (SIZE_W'(r_cur.off + r_cur.len) == r_rdata.off);
        o_status.merge_prv  = !r_rdata.used &&
                              (SIZE_W'(r_rdata.off + r_rdata.len) == r_cur.off);
    end

    // Table write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_rdata;
        if (w_cfg_size) begin
            w_we    = 1'b1;
            w_wdata = '{used: 1'b0, len: i_cfg_data[SIZE_W-1:0], off: '0};
        end else begin
            case (i_op)
                DP_INIT: begin
                    w_we    = 1'b1;
                    w_wdata = '{used: 1'b0, len: r_pool_size, off: '0};
                end
                DP_WR_K, DP_WR_DN: begin
                    w_we    = 1'b1;
                    w_waddr = r_k[IW-1:0];
                end
                DP_SPLIT_NEW: begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_p1[IW-1:0];
                    w_wdata = '{used: 1'b0, len: SIZE_W'(r_cur.len - r_want),
                                off: SIZE_W'(r_cur.off + r_want)};
                end
                DP_ALLOC_DONE: begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = '{used: 1'b1, len: (w_split ? r_want : r_cur.len),
                                off: r_cur.off};
                end
                DP_MERGE_PRV: begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_m1[IW-1:0];
                    w_wdata = '{used: 1'b0, len: SIZE_W'(r_rdata.len + r_cur.len),
                                off: r_rdata.off};
                end
                DP_WR_CUR: begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = '{used: 1'b0, len: r_cur.len, off: r_cur.off};
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // Table read port.
    always_comb begin
        w_re    = 1'b1;
        w_raddr = '0;
        case (i_op)
            DP_RD_IDX: w_raddr = r_idx[IW-1:0];
            DP_RD_KM1: w_raddr = w_k_m1[IW-1:0];
            DP_RD_KP1: w_raddr = w_k_p1[IW-1:0];
            DP_RD_NXT: w_raddr = w_idx_p1[IW-1:0];
            DP_RD_PRV: w_raddr = w_idx_m1[IW-1:0];
            default:   w_re    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= POOL_BASE_RST;
            r_pool_size <= POOL_SIZE_RST;
            r_total     <= TW'(1);
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_POOL_BASE)) begin
                r_pool_base <= i_cfg_data;
            end
            if (w_cfg_size) begin
                r_pool_size <= i_cfg_data[SIZE_W-1:0];
                r_total     <= TW'(1);
            end else begin
                case (i_op)
                    DP_INIT:       r_total <= TW'(1);
                    DP_ALLOC_DONE: r_total <= r_total + TW'(w_split);
                    DP_DEC:        r_total <= r_total - TW'(1);
                    default:       r_total <= r_total;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_idx      <= '0;
                r_want     <= i_request_size;
                r_rel      <= i_release_addr;
                r_is_free  <= i_action;
                r_res_ok   <= 1'b0;
                r_res_addr <= '0;
            end
            DP_FAIL: begin
                r_res_ok   <= 1'b0;
                r_res_addr <= '0;
            end
            DP_ADV: r_idx <= r_idx + TW'(1);
            DP_TAKE: begin
                r_cur <= r_rdata;
                r_k   <= r_total;
                if (r_is_free) begin
                    r_res_ok <= 1'b1;
                end
            end
            DP_WR_K:  r_k <= w_k_m1;
            DP_WR_DN: r_k <= w_k_p1;
            DP_ALLOC_DONE: begin
                r_res_ok   <= 1'b1;
                r_res_addr <= w_cur_addr;
            end
            DP_MERGE_NXT: begin
                r_cur.len <= SIZE_W'(r_cur.len + r_rdata.len);
                r_k       <= w_idx_p1;
            end
            DP_MERGE_PRV: r_k <= r_idx;
            DP_PUSH: begin
                r_o_addr <= r_res_addr;
                r_o_ok   <= r_res_ok;
                r_o_cnt  <= w_total_wide[CNT_W-1:0];
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_result_addr    = r_o_addr;
    assign o_success        = r_o_ok;
    assign o_entries_in_use = r_o_cnt;

    `FFBA_ASSERT_IMP(a_total_range, i_clk, i_rst_n, 1'b1,
        (r_total >= TW'(1)) && (r_total <= TW'(TABLE_DEPTH)), "table count out of range")
    `FFBA_ASSERT_NXT(a_split_grows, i_clk, i_rst_n,
        (i_op == DP_ALLOC_DONE) && w_split && !w_cfg_size,
        r_total == $past(r_total) + TW'(1), "split did not add an entry")
    `FFBA_ASSERT_IMP(a_dec_nonempty, i_clk, i_rst_n, i_op == DP_DEC,
        r_total > TW'(1), "merge removed the last entry")

endmodule

FILE: sv/ffba_ctrl.sv
// Controller state machine of the allocator: sequences scan, shift and merge steps.
module ffba_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ffba_pkg::t_dp_status i_status,
    output ffba_pkg::t_dp_op     o_op
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_A_DEC,
        S_UP_WR,
        S_A_FIN,
        S_F_NXT,
        S_F_NCHK,
        S_DN_RD,
        S_DN_WR,
        S_F_PRV,
        S_F_PCHK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_after_prv;
    logic   n_after_prv;

    always_comb begin
        n_state     = r_state;
        n_after_prv = r_after_prv;
        o_op        = DP_NOP;
        case (r_state)
            S_INIT: begin
                o_op    = DP_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!i_status.is_free && i_status.want_zero) begin
                    o_op    = DP_FAIL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.idx_end) begin
                    o_op    = DP_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_op    = DP_RD_IDX;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.hit) begin
                    o_op    = DP_TAKE;
                    n_state = i_status.is_free ? S_F_NXT : S_A_DEC;
                end else begin
                    o_op    = DP_ADV;
                    n_state = S_SCAN_RD;
                end
            end
            // Open a gap after the chosen entry, top entry first.
            S_A_DEC: begin
                if (i_status.split && i_status.up_more) begin
                    o_op    = DP_RD_KM1;
                    n_state = S_UP_WR;
                end else if (i_status.split) begin
                    o_op    = DP_SPLIT_NEW;
                    n_state = S_A_FIN;
                end else begin
                    o_op    = DP_ALLOC_DONE;
                    n_state = S_DONE;
                end
            end
            S_UP_WR: begin
                o_op    = DP_WR_K;
                n_state = S_A_DEC;
            end
            S_A_FIN: begin
                o_op    = DP_ALLOC_DONE;
                n_state = S_DONE;
            end
            S_F_NXT: begin
                if (i_status.nxt_exists) begin
                    o_op    = DP_RD_NXT;
                    n_state = S_F_NCHK;
                end else begin
                    n_state = S_F_PRV;
                end
            end
            S_F_NCHK: begin
                if (i_status.merge_nxt) begin
                    o_op        = DP_MERGE_NXT;
                    n_after_prv = 1'b0;
                    n_state     = S_DN_RD;
                end else begin
                    n_state = S_F_PRV;
                end
            end
            // Close the gap left by a merged entry.
            S_DN_RD: begin
                if (i_status.dn_more) begin
                    o_op    = DP_RD_KP1;
                    n_state = S_DN_WR;
                end else begin
                    o_op    = DP_DEC;
                    n_state = r_after_prv ? S_DONE : S_F_PRV;
                end
            end
            S_DN_WR: begin
                o_op    = DP_WR_DN;
                n_state = S_DN_RD;
            end
            S_F_PRV: begin
                if (i_status.idx_nz) begin
                    o_op    = DP_RD_PRV;
                    n_state = S_F_PCHK;
                end else begin
                    o_op    = DP_WR_CUR;
                    n_state = S_DONE;
                end
            end
            S_F_PCHK: begin
                if (i_status.merge_prv) begin
                    o_op        = DP_MERGE_PRV;
                    n_after_prv = 1'b1;
                    n_state     = S_DN_RD;
                end else begin
                    o_op    = DP_WR_CUR;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op    = DP_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_after_prv <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after_prv <= n_after_prv;
            if (o_op == DP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
